// ----- hw/rtl/opc_pkg.sv -----
package opc_pkg;

   localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
   localparam logic [4:0]  FIELD_START = 5'd22;
   localparam logic [4:0]  FIELD_END   = 5'd26;

   typedef struct packed {
      logic go;
      logic last;
   } step_ctl_type;

   // msb-first crc over one byte, unrolled eight bit steps
   function automatic logic [31:0] crc_absorb(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {data, 24'h00_0000};
      for (int k = 0; k < 8; k++) begin
         if (c[31]) begin
            c = {c[30:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[30:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/opc_crc_core.sv -----
module opc_crc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  opc_pkg::step_ctl_type ctl,
   input  logic [7:0]            page_byte,
   output logic [31:0]           crc_next
);
   import opc_pkg::*;

   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic [4:0]  pos_ff;
   logic [4:0]  pos_in;
   logic        in_field;
   logic [7:0]  byte_eff;

   // the page's own crc field is taken as zero
   assign in_field = (pos_ff >= FIELD_START) && (pos_ff < FIELD_END);
   assign byte_eff = in_field ? 8'h00 : page_byte;
   assign crc_next = crc_absorb(crc_ff, byte_eff);

   always_comb begin
      crc_in = crc_ff;
      pos_in = pos_ff;
      if (ctl.go) begin
         if (ctl.last) begin
            crc_in = '0;
            pos_in = '0;
         end else begin
            crc_in = crc_next;
            if (pos_ff < FIELD_END) begin
               pos_in = pos_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
         pos_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         pos_ff <= pos_in;
      end
   end

endmodule

// ----- hw/rtl/ogg_page_crc32.sv -----
// channel | ports                                   | direction
// req     | req_valid, req_stall, req_page_byte,    | in
//         | req_last_byte                           |
// rsp     | rsp_valid, rsp_stall, rsp_page_crc      | out
//
// one item per cycle unless a last byte waits on a stalled rsp: an input register
// feeds a byte-wide crc update, and a last byte's result goes to an output register.
// a last byte's crc appears on rsp after passing the input and output registers.
// synchronous active-high reset clears the crc, the byte position and all valids.
// rsp_stall holds only an item carrying a last byte; other bytes keep flowing.
module ogg_page_crc32 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_page_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_page_crc
);
   import opc_pkg::*;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   logic [7:0]   s1_byte_ff;
   logic         s1_last_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic [31:0]  rsp_crc_ff;
   logic [31:0]  crc_next;
   logic         out_free;
   logic         s1_go;
   logic         req_take;
   step_ctl_type ctl;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // only a last byte needs room in the output register
   assign s1_go     = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   assign ctl.go   = s1_go;
   assign ctl.last = s1_last_ff;

   opc_crc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .page_byte (s1_byte_ff),
      .crc_next  (crc_next)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s1_go && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_page_byte;
         s1_last_ff <= req_last_byte;
      end
      if (s1_go && s1_last_ff) begin
         rsp_crc_ff <= crc_next;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_page_crc = rsp_crc_ff;

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> rsp_valid_ff)
      else $error("last byte did not produce a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff && rsp_valid_ff) |-> !rsp_stall)
      else $error("pending result overwritten");

   a_stall_only_on_last: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked result");

endmodule

// ----- test/ogg_page_crc32_tb.sv -----
`timescale 1ns / 100ps

module ogg_page_crc32_tb;
   import opc_pkg::*;

   typedef struct {
      logic [7:0]  data;
      logic        last;
      int unsigned reps;
      logic        known;
      logic [31:0] crc;
   } page_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_page_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_page_crc;

   // predicted crc of each page, oldest first
   logic [31:0] crc_due[$];
   logic [31:0] page_crc_acc;
   logic [4:0]  page_pos;
   logic [31:0] want_crc;

   int unsigned send_idle_pct;
   int unsigned sink_stall_pct;
   int unsigned bytes_sent;
   int unsigned pages_sent;
   int unsigned crcs_checked;
   int unsigned fault_count;

   page_row_type page_rows[$] = '{
      '{8'h00, 1'b1, 1,  1'b1, 32'h0000_0000},  // one zero byte leaves the crc at zero
      '{8'hFF, 1'b1, 1,  1'b0, 32'h0},
      '{8'hA5, 1'b0, 22, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 4,  1'b0, 32'h0},          // crc field, counted as zero
      '{8'h5A, 1'b1, 1,  1'b0, 32'h0}           // first byte past the field ends the page
   };

   ogg_page_crc32 DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_page_byte (req_page_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_page_crc  (rsp_page_crc)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #10 clock = ~clock;
      end
   end

   // msb-first crc, one message bit at a time
   function automatic logic [31:0] crc_fold_byte(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] r;
      logic        fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[31] ^ b[i];
         r  = {r[30:0], 1'b0};
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   task automatic absorb_byte(input logic [7:0] b, input logic l, input logic known,
                              input logic [31:0] known_crc);
      logic [7:0] fed;
      fed = (page_pos >= FIELD_START && page_pos < FIELD_END) ? 8'h00 : b;
      page_crc_acc = crc_fold_byte(page_crc_acc, fed);
      if (page_pos < FIELD_END) begin
         page_pos++;
      end
      if (l) begin
         crc_due.push_back(known ? known_crc : page_crc_acc);
         page_crc_acc = '0;
         page_pos     = '0;
         pages_sent++;
      end
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_byte(input logic [7:0] b, input logic l, input logic known,
                            input logic [31:0] known_crc);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_page_byte <= b;
      req_last_byte <= l;
      do begin
         @(posedge clock);
      end while (req_stall);
      absorb_byte(b, l, known, known_crc);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_page(input int unsigned len);
      for (int unsigned k = 1; k <= len; k++) begin
         send_byte(8'($urandom), k == len, 1'b0, 32'h0);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (crc_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 99) < sink_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (crc_due.size() == 0) begin
            $error("page_crc: unexpected result, actual %h", rsp_page_crc);
            fault_count++;
         end else begin
            want_crc = crc_due.pop_front();
            crcs_checked++;
            if (rsp_page_crc !== want_crc) begin
               $error("page_crc mismatch: expected %h, actual %h", want_crc, rsp_page_crc);
               fault_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int unsigned phase_start;
      int unsigned bin;
      int unsigned len;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_page_byte  = 8'h00;
      req_last_byte  = 1'b0;
      page_crc_acc   = '0;
      page_pos       = '0;
      send_idle_pct  = 0;
      sink_stall_pct = 0;
      bytes_sent     = 0;
      pages_sent     = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (page_rows[r]) begin
         for (int unsigned k = 1; k <= page_rows[r].reps; k++) begin
            send_byte(page_rows[r].data, page_rows[r].last && k == page_rows[r].reps,
                      page_rows[r].known, page_rows[r].crc);
         end
      end
      wait_drained();

      // no idling, sender idle, receiver stalling, then both a little
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin send_idle_pct = 71; sink_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  sink_stall_pct = 71; end
            default: begin send_idle_pct = 15; sink_stall_pct = 15; end
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 420) begin
            bin = $urandom_range(0, 9);
            if (bin < 3) begin
               len = $urandom_range(1, 21);
            end else if (bin < 6) begin
               len = $urandom_range(22, 27);   // ends just before, in or just past the crc field
            end else if (bin < 9) begin
               len = $urandom_range(28, 60);
            end else begin
               len = $urandom_range(61, 200);
            end
            send_page(len);
         end
         // hold off the sender until every crc of this phase is back
         wait_drained();
      end

      send_idle_pct  = 0;
      sink_stall_pct = 0;
      repeat (10) @(posedge clock);
      $display("covered %0d bytes in %0d pages, %0d page crcs checked, %0d faults",
               bytes_sent, pages_sent, crcs_checked, fault_count);
      $display("pages ran from one byte to 200, ending before, inside and past the crc field");
      if (fault_count == 0 && crc_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/opc_pkg.sv
hw/rtl/opc_crc_core.sv
hw/rtl/ogg_page_crc32.sv
test/ogg_page_crc32_tb.sv
